@@ hw/rtl/pfd_pkg.sv @@
package pfd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int ALPHA_BITS = 16;
    localparam int ALPHA_W    = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    localparam int GAIN_W  = 32;
    localparam int COEF_W  = 31;
    localparam int MUL_B_W = 33;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_KP             = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI             = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD             = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INV_DT         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

    localparam logic [COEF_W-1:0]  RST_INV_DT         = 31'd65536;
    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA   = 17'd65536;
    localparam logic [COEF_W-1:0]  RST_INTEGRAL_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [COEF_W-1:0]        inv_dt;
        logic [ALPHA_W-1:0]       filter_alpha;
        logic [COEF_W-1:0]        integral_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_RAW,
        MUL_P,
        MUL_FD,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef struct packed {
        logic     cap_err;
        t_mul_sel mul_sel;
        logic     ld_raw;
        logic     ld_p;
        logic     ld_filt;
        logic     ld_integ;
        logic     ld_d;
        logic     ld_out;
    } t_cmd;

endpackage

@@ hw/rtl/pfd_in_if.sv @@
interface pfd_in_if #(
    parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

@@ hw/rtl/pfd_out_if.sv @@
interface pfd_out_if #(
    parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         integral_clamped;

    modport source (output valid, output drive, output integral_clamped, input ready);
    modport sink   (input valid, input drive, input integral_clamped, output ready);
endinterface

@@ hw/rtl/pfd_regs.sv @@
module pfd_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output pfd_pkg::t_cfg                     o_cfg
);

    pfd_pkg::t_cfg                      r_cfg;
    pfd_pkg::t_cfg                      n_cfg;
    logic [pfd_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                               wr_en;

    assign reg_idx = paddr[pfd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                pfd_pkg::REG_KP:             n_cfg.kp = pwdata;
                pfd_pkg::REG_KI:             n_cfg.ki = pwdata;
                pfd_pkg::REG_KD:             n_cfg.kd = pwdata;
                pfd_pkg::REG_INV_DT:         n_cfg.inv_dt = pwdata[pfd_pkg::COEF_W-1:0];
                pfd_pkg::REG_FILTER_ALPHA:   n_cfg.filter_alpha = pwdata[pfd_pkg::ALPHA_W-1:0];
                pfd_pkg::REG_INTEGRAL_LIMIT: n_cfg.integral_limit = pwdata[pfd_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pfd_pkg::REG_KP:             prdata = r_cfg.kp;
            pfd_pkg::REG_KI:             prdata = r_cfg.ki;
            pfd_pkg::REG_KD:             prdata = r_cfg.kd;
            pfd_pkg::REG_INV_DT:         prdata = {1'b0, r_cfg.inv_dt};
            pfd_pkg::REG_FILTER_ALPHA:   prdata = {15'd0, r_cfg.filter_alpha};
            pfd_pkg::REG_INTEGRAL_LIMIT: prdata = {1'b0, r_cfg.integral_limit};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp             <= '0;
            r_cfg.ki             <= '0;
            r_cfg.kd             <= '0;
            r_cfg.inv_dt         <= pfd_pkg::RST_INV_DT;
            r_cfg.filter_alpha   <= pfd_pkg::RST_FILTER_ALPHA;
            r_cfg.integral_limit <= pfd_pkg::RST_INTEGRAL_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ hw/rtl/pfd_ctrl.sv @@
module pfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pfd_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAW,
        S_P,
        S_FD,
        S_I,
        S_D,
        S_DSAT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid & ~i_out_ready;
        o_cmd           = '0;
        o_cmd.mul_sel   = pfd_pkg::MUL_RAW;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_err = 1'b1;
                    n_state       = S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.mul_sel = pfd_pkg::MUL_RAW;
                n_state       = S_P;
            end
            S_P: begin
                o_cmd.ld_raw  = 1'b1;
                o_cmd.mul_sel = pfd_pkg::MUL_P;
                n_state       = S_FD;
            end
            S_FD: begin
                o_cmd.ld_p    = 1'b1;
                o_cmd.mul_sel = pfd_pkg::MUL_FD;
                n_state       = S_I;
            end
            S_I: begin
                o_cmd.ld_filt = 1'b1;
                o_cmd.mul_sel = pfd_pkg::MUL_I;
                n_state       = S_D;
            end
            S_D: begin
                o_cmd.ld_integ = 1'b1;
                o_cmd.mul_sel  = pfd_pkg::MUL_D;
                n_state        = S_DSAT;
            end
            S_DSAT: begin
                o_cmd.ld_d = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/pfd_dp.sv @@
module pfd_dp #(
    parameter int FRAC_BITS  = pfd_pkg::FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pfd_pkg::t_cfg                         i_cfg,
    input  pfd_pkg::t_cmd                         i_cmd,
    input  logic signed [pfd_pkg::DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [pfd_pkg::DATA_WIDTH-1:0] i_measurement,
    output logic signed [pfd_pkg::DATA_WIDTH-1:0] o_drive,
    output logic                                  o_integral_clamped
);

    localparam int DW = pfd_pkg::DATA_WIDTH;
    localparam int AW = DW + 1;
    localparam int BW = pfd_pkg::MUL_B_W;
    localparam int PW = AW + BW;
    localparam logic signed [PW-1:0] SMAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW-1:0] SMIN = ~SMAX;

    function automatic logic signed [DW-1:0] f_sat(input logic signed [PW-1:0] x);
        logic signed [DW-1:0] y;
        if (x > SMAX) begin
            y = SMAX[DW-1:0];
        end else if (x < SMIN) begin
            y = SMIN[DW-1:0];
        end else begin
            y = x[DW-1:0];
        end
        return y;
    endfunction

    logic signed [DW-1:0] r_err;
    logic signed [DW-1:0] r_prev;
    logic signed [DW-1:0] r_filt;
    logic signed [DW-1:0] r_integ;
    logic signed [DW-1:0] r_raw;
    logic signed [DW-1:0] r_p;
    logic signed [DW-1:0] r_d;
    logic                 r_clamp;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_drive;
    logic                 r_out_clamp;

    logic [pfd_pkg::ALPHA_W-1:0] alpha_eff;
    logic signed [AW-1:0]        mul_a;
    logic signed [BW-1:0]        mul_b;
    logic signed [PW-1:0]        mul_prod;
    logic signed [PW-1:0]        sh_f;
    logic signed [PW-1:0]        sh_a;
    logic signed [DW-1:0]        sat_f;
    logic signed [PW-1:0]        filt_sum;
    logic signed [PW-1:0]        isum;
    logic signed [PW-1:0]        lim_raw;
    logic signed [PW-1:0]        lim;
    logic signed [PW-1:0]        isum_clamped;
    logic                        isum_hit;
    logic signed [PW-1:0]        drive_sum;

    assign alpha_eff = i_cfg.filter_alpha[pfd_pkg::ALPHA_W-1] ? pfd_pkg::ALPHA_ONE
                                                              : i_cfg.filter_alpha;

    always_comb begin
        case (i_cmd.mul_sel)
            pfd_pkg::MUL_RAW: begin
                mul_a = AW'(r_err) - AW'(r_prev);
                mul_b = $signed({2'b00, i_cfg.inv_dt});
            end
            pfd_pkg::MUL_P: begin
                mul_a = AW'(r_err);
                mul_b = BW'(i_cfg.kp);
            end
            pfd_pkg::MUL_FD: begin
                mul_a = AW'(r_raw) - AW'(r_filt);
                mul_b = $signed({16'd0, alpha_eff});
            end
            pfd_pkg::MUL_I: begin
                mul_a = AW'(r_err);
                mul_b = BW'(i_cfg.ki);
            end
            pfd_pkg::MUL_D: begin
                mul_a = AW'(r_filt);
                mul_b = BW'(i_cfg.kd);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    // Arithmetic shifts floor the scaled product toward minus infinity.
    assign sh_f     = r_prod >>> FRAC_BITS;
    assign sh_a     = r_prod >>> pfd_pkg::ALPHA_BITS;
    assign sat_f    = f_sat(sh_f);
    assign filt_sum = PW'(r_filt) + sh_a;

    assign lim_raw = $signed(PW'(i_cfg.integral_limit));
    assign lim     = (lim_raw > SMAX) ? SMAX : lim_raw;
    assign isum    = PW'(r_integ) + PW'(sat_f);

    always_comb begin
        isum_clamped = isum;
        isum_hit     = 1'b0;
        if (isum > lim) begin
            isum_clamped = lim;
            isum_hit     = 1'b1;
        end else if (isum < -lim) begin
            isum_clamped = -lim;
            isum_hit     = 1'b1;
        end
    end

    assign drive_sum = PW'(r_p) + PW'(r_integ) + PW'(r_d);

    always_ff @(posedge i_clk) begin
        r_prod <= mul_prod;
        if (i_cmd.cap_err) begin
            r_err <= f_sat(PW'(i_setpoint) - PW'(i_measurement));
        end
        if (i_cmd.ld_raw) begin
            r_raw <= sat_f;
        end
        if (i_cmd.ld_p) begin
            r_p <= sat_f;
        end
        if (i_cmd.ld_d) begin
            r_d <= sat_f;
        end
        if (i_cmd.ld_out) begin
            r_drive     <= f_sat(drive_sum);
            r_out_clamp <= r_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_filt  <= '0;
            r_integ <= '0;
            r_clamp <= 1'b0;
        end else begin
            if (i_cmd.ld_filt) begin
                r_filt <= f_sat(filt_sum);
            end
            if (i_cmd.ld_integ) begin
                r_integ <= isum_clamped[DW-1:0];
                r_clamp <= isum_hit;
            end
            if (i_cmd.ld_d) begin
                r_prev <= r_err;
            end
        end
    end

    assign o_drive            = r_drive;
    assign o_integral_clamped = r_out_clamp;

endmodule

@@ hw/rtl/pid_filtered_derivative_top.sv @@
// Channel   Direction  Handshake      Beat contents
// i_sample  in         valid/ready    setpoint, measurement
// o_result  out        valid/ready    drive, integral_clamped
// APB       in/out     psel/penable   kp, ki, kd, inv_dt, filter_alpha, integral_limit
//
// Each sample needs five products, which pass one at a time through a single
// shared multiplier, each followed by a registered scaling and saturation step.
// A sample is accepted only while the controller is idle, so samples never overlap.
// A new sample is accepted while a finished result beat still waits on o_result.
// Reset is synchronous and clears the loop state and the handshake control.
module pid_filtered_derivative_top #(
    parameter int FRAC_BITS  = pfd_pkg::FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pfd_in_if.sink                         i_sample,
    pfd_out_if.source                      o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    pfd_pkg::t_cfg cfg;
    pfd_pkg::t_cmd cmd;

    pfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    pfd_dp #(
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .i_setpoint         (i_sample.setpoint),
        .i_measurement      (i_sample.measurement),
        .o_drive            (o_result.drive),
        .o_integral_clamped (o_result.integral_clamped)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int DATA_WIDTH = pfd_pkg::DATA_WIDTH;
    localparam int FRAC_BITS  = pfd_pkg::FRAC_BITS;
    localparam int ALPHA_BITS = pfd_pkg::ALPHA_BITS;
    localparam int ALPHA_W    = pfd_pkg::ALPHA_W;
    localparam int GAIN_W     = pfd_pkg::GAIN_W;
    localparam int COEF_W     = pfd_pkg::COEF_W;
    localparam int APB_DATA_W = pfd_pkg::APB_DATA_W;
    localparam int APB_ADDR_W = pfd_pkg::APB_ADDR_W;
    localparam int REG_IDX_W  = pfd_pkg::REG_IDX_W;

    localparam logic [ALPHA_W-1:0]   ALPHA_ONE          = pfd_pkg::ALPHA_ONE;
    localparam logic [REG_IDX_W-1:0] REG_KP             = pfd_pkg::REG_KP;
    localparam logic [REG_IDX_W-1:0] REG_KI             = pfd_pkg::REG_KI;
    localparam logic [REG_IDX_W-1:0] REG_KD             = pfd_pkg::REG_KD;
    localparam logic [REG_IDX_W-1:0] REG_INV_DT         = pfd_pkg::REG_INV_DT;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA   = pfd_pkg::REG_FILTER_ALPHA;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = pfd_pkg::REG_INTEGRAL_LIMIT;
    localparam logic [COEF_W-1:0]    RST_INV_DT         = pfd_pkg::RST_INV_DT;
    localparam logic [ALPHA_W-1:0]   RST_FILTER_ALPHA   = pfd_pkg::RST_FILTER_ALPHA;
    localparam logic [COEF_W-1:0]    RST_INTEGRAL_LIMIT = pfd_pkg::RST_INTEGRAL_LIMIT;

    localparam int                        CYCLE_LIMIT     = 400000;
    localparam int                        HOLD_CYCLES     = 120;
    localparam int                        RAND_PHASES     = 10;
    localparam int                        ITEMS_PER_PHASE = 93;
    localparam int                        HOLD_PHASE      = 2;
    localparam int                        PAUSE_PHASE     = 6;
    localparam int                        DRAIN_TAIL      = 24;
    localparam logic [REG_IDX_W-1:0]      REG_SPARE_A     = 3'd6;
    localparam logic [REG_IDX_W-1:0]      REG_SPARE_B     = 3'd7;
    localparam logic signed [127:0]       DATA_HI = (128'sd1 <<< (DATA_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0]       DATA_LO = -DATA_HI - 128'sd1;
    localparam logic signed [DATA_WIDTH-1:0] Q_ONE = 32'sd65536;
    localparam logic signed [DATA_WIDTH-1:0] D_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         clamped;
    } t_drive_beat;

    typedef struct {
        bit                           is_cfg;
        logic [REG_IDX_W-1:0]         reg_idx;
        logic [APB_DATA_W-1:0]        wdata;
        logic signed [DATA_WIDTH-1:0] setpoint;
        logic signed [DATA_WIDTH-1:0] measurement;
        bit                           known;
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         clamped;
    } t_step_row;

    typedef enum {
        RX_FREE,
        RX_COIN,
        RX_THIRD
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pfd_in_if  sample_bus ();
    pfd_out_if result_bus ();

    pid_filtered_derivative_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Controller settings as the block should hold them.
    logic signed [GAIN_W-1:0] gain_p      = '0;
    logic signed [GAIN_W-1:0] gain_i      = '0;
    logic signed [GAIN_W-1:0] gain_d      = '0;
    logic [COEF_W-1:0]        rate_inv    = RST_INV_DT;
    logic [ALPHA_W-1:0]       filter_coef = RST_FILTER_ALPHA;
    logic [COEF_W-1:0]        integ_limit = RST_INTEGRAL_LIMIT;

    // Loop state of the controller.
    logic signed [DATA_WIDTH-1:0] last_error  = '0;
    logic signed [DATA_WIDTH-1:0] deriv_state = '0;
    logic signed [DATA_WIDTH-1:0] integ_state = '0;

    t_drive_beat pending_drives[$];
    t_drive_beat model_beat;
    t_drive_beat want;

    logic                         row_known;
    logic signed [DATA_WIDTH-1:0] row_drive;
    logic                         row_clamped;
    bit                           hold_toggle;

    int fail_count;
    int samples_taken;
    int results_checked;
    int clamped_seen;
    int settings_used;
    int cycle_count;

    function automatic logic signed [DATA_WIDTH-1:0] clip_data(input logic signed [127:0] x);
        if (x > DATA_HI) begin
            return DATA_HI[DATA_WIDTH-1:0];
        end
        if (x < DATA_LO) begin
            return DATA_LO[DATA_WIDTH-1:0];
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [127:0] scaled_product(input logic signed [127:0] a,
                                                           input logic signed [127:0] b,
                                                           input int unsigned shift);
        return (a * b) >>> shift;
    endfunction

    function automatic t_drive_beat predict_drive(input logic signed [DATA_WIDTH-1:0] sp,
                                                  input logic signed [DATA_WIDTH-1:0] ms);
        logic signed [127:0]          sp_w, ms_w, err_w, last_w, raw_w, filt_w;
        logic signed [127:0]          ki_w, acc_w, lim_w, p_w, d_w;
        logic signed [DATA_WIDTH-1:0] err, raw, filt, p_term, d_term, ki_term;
        logic [ALPHA_W-1:0]           alpha_eff;
        t_drive_beat                  beat;
        sp_w = 128'(sp);
        ms_w = 128'(ms);
        err = clip_data(sp_w - ms_w);
        err_w = 128'(err);
        last_w = 128'(last_error);
        raw = clip_data(scaled_product(err_w - last_w, 128'(rate_inv), FRAC_BITS));
        alpha_eff = (filter_coef > ALPHA_ONE) ? ALPHA_ONE : filter_coef;
        raw_w = 128'(raw);
        filt_w = 128'(deriv_state);
        filt = clip_data(filt_w + scaled_product(raw_w - filt_w, 128'(alpha_eff), ALPHA_BITS));
        last_error = err;
        deriv_state = filt;

        p_term = clip_data(scaled_product(128'(gain_p), 128'(err), FRAC_BITS));
        d_term = clip_data(scaled_product(128'(gain_d), 128'(filt), FRAC_BITS));
        ki_term = clip_data(scaled_product(128'(gain_i), 128'(err), FRAC_BITS));

        acc_w = 128'(integ_state);
        ki_w = 128'(ki_term);
        acc_w = acc_w + ki_w;
        lim_w = 128'(integ_limit);
        beat.clamped = 1'b0;
        if (acc_w > lim_w) begin
            acc_w = lim_w;
            beat.clamped = 1'b1;
        end else if (acc_w < -lim_w) begin
            acc_w = -lim_w;
            beat.clamped = 1'b1;
        end
        integ_state = acc_w[DATA_WIDTH-1:0];

        p_w = 128'(p_term);
        d_w = 128'(d_term);
        beat.drive = clip_data(p_w + acc_w + d_w);
        return beat;
    endfunction

    function automatic t_step_row cfg_row(input logic [REG_IDX_W-1:0] idx,
                                          input logic [APB_DATA_W-1:0] value);
        t_step_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.wdata = value;
        return r;
    endfunction

    function automatic t_step_row sample_row(input logic signed [DATA_WIDTH-1:0] sp,
                                             input logic signed [DATA_WIDTH-1:0] ms);
        t_step_row r;
        r = '{default: '0};
        r.setpoint = sp;
        r.measurement = ms;
        return r;
    endfunction

    function automatic t_step_row known_row(input logic signed [DATA_WIDTH-1:0] sp,
                                            input logic signed [DATA_WIDTH-1:0] ms,
                                            input logic signed [DATA_WIDTH-1:0] drive,
                                            input logic clamped);
        t_step_row r;
        r = sample_row(sp, ms);
        r.known = 1'b1;
        r.drive = drive;
        r.clamped = clamped;
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return D_MAX;
            2: return D_MIN;
            3: return $urandom;
            default: return $signed($urandom_range(0, 4 * 65536)) - 32'sd131072;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_rate();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return RST_INTEGRAL_LIMIT;
            2: return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(1, 16 << 16));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] rand_alpha();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALPHA_ONE;
            2: return 17'h1_FFFF;
            3: return ALPHA_W'($urandom_range(65537, 131071));
            default: return ALPHA_W'($urandom_range(1, 65536));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return RST_INTEGRAL_LIMIT;
            2: return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(0, 500 << 16));
        endcase
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return D_MAX;
            1: return D_MIN;
            2: return '0;
            3, 4, 5: return $urandom;
            default: return $signed($urandom_range(0, 32 << 16)) - 32'sd1048576;
        endcase
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KP:             gain_p = value;
            REG_KI:             gain_i = value;
            REG_KD:             gain_d = value;
            REG_INV_DT:         rate_inv = value[COEF_W-1:0];
            REG_FILTER_ALPHA:   filter_coef = value[ALPHA_W-1:0];
            REG_INTEGRAL_LIMIT: integ_limit = value[COEF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic offer_sample(input logic signed [DATA_WIDTH-1:0] sp,
                                input logic signed [DATA_WIDTH-1:0] ms,
                                input bit known,
                                input logic signed [DATA_WIDTH-1:0] drive,
                                input logic clamped);
        sample_bus.valid <= 1'b1;
        sample_bus.setpoint <= sp;
        sample_bus.measurement <= ms;
        row_known <= known;
        row_drive <= drive;
        row_clamped <= clamped;
        @(posedge i_clk);
        while (!sample_bus.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        sample_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drives.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pid_filtered_derivative_top verification failed");
        $finish;
    end

    // The receiver stalls on its own schedule and, on request, holds off for a long stretch.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        bit       hold_seen;
        mode = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        hold_seen = 1'b0;
        result_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_FREE: result_bus.ready <= 1'b1;
                    RX_COIN: result_bus.ready <= 1'($urandom_range(0, 1));
                    default: result_bus.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sample_bus.valid && sample_bus.ready) begin
            model_beat = predict_drive(sample_bus.setpoint, sample_bus.measurement);
            if (row_known) begin
                pending_drives.push_back('{row_drive, row_clamped});
            end else begin
                pending_drives.push_back(model_beat);
            end
            samples_taken++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_drives.size() == 0) begin
                $error("result beat with no sample waiting: drive %0d, integral_clamped %0b",
                       result_bus.drive, result_bus.integral_clamped);
                fail_count++;
            end else begin
                want = pending_drives.pop_front();
                if (result_bus.drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, result_bus.drive);
                    fail_count++;
                end
                if (result_bus.integral_clamped !== want.clamped) begin
                    $error("integral_clamped: expected %0b, got %0b",
                           want.clamped, result_bus.integral_clamped);
                    fail_count++;
                end
                results_checked++;
                if (result_bus.integral_clamped === 1'b1) begin
                    clamped_seen++;
                end
            end
        end
    end

    initial begin
        t_step_row                    dir_rows[$];
        logic signed [DATA_WIDTH-1:0] sp;
        logic signed [DATA_WIDTH-1:0] ms;
        int                           burst_left;
        int                           gap;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_bus.valid = 1'b0;
        sample_bus.setpoint = '0;
        sample_bus.measurement = '0;
        row_known = 1'b0;
        row_drive = '0;
        row_clamped = 1'b0;
        hold_toggle = 1'b0;

        dir_rows.push_back(known_row(0, 0, 0, 1'b0));
        dir_rows.push_back(known_row(D_MAX, D_MIN, 0, 1'b0));
        dir_rows.push_back(cfg_row(REG_KP, Q_ONE));
        dir_rows.push_back(known_row(D_MAX, D_MIN, D_MAX, 1'b0));
        dir_rows.push_back(known_row(D_MIN, D_MAX, D_MIN, 1'b0));
        dir_rows.push_back(known_row(100 << 16, 30 << 16, 70 << 16, 1'b0));
        dir_rows.push_back(known_row(-1, 0, -1, 1'b0));
        dir_rows.push_back(cfg_row(REG_KP, 0));
        dir_rows.push_back(cfg_row(REG_KI, Q_ONE));
        dir_rows.push_back(cfg_row(REG_INTEGRAL_LIMIT, 10 << 16));
        dir_rows.push_back(known_row(100 << 16, 0, 10 << 16, 1'b1));
        dir_rows.push_back(known_row(0, 100 << 16, -(10 << 16), 1'b1));
        dir_rows.push_back(known_row(5 << 16, 0, -(5 << 16), 1'b0));
        dir_rows.push_back(cfg_row(REG_INTEGRAL_LIMIT, 0));
        dir_rows.push_back(known_row(0, 0, 0, 1'b1));
        dir_rows.push_back(cfg_row(REG_INTEGRAL_LIMIT, APB_DATA_W'(RST_INTEGRAL_LIMIT)));
        dir_rows.push_back(cfg_row(REG_KI, D_MAX));
        dir_rows.push_back(cfg_row(REG_KP, D_MAX));
        dir_rows.push_back(known_row(D_MAX, D_MIN, D_MAX, 1'b0));
        dir_rows.push_back(known_row(D_MAX, D_MIN, D_MAX, 1'b1));
        dir_rows.push_back(cfg_row(REG_KP, D_MIN));
        dir_rows.push_back(cfg_row(REG_KI, D_MIN));
        dir_rows.push_back(sample_row(D_MAX, D_MIN));
        dir_rows.push_back(sample_row(D_MIN, D_MAX));
        dir_rows.push_back(cfg_row(REG_KP, 0));
        dir_rows.push_back(cfg_row(REG_KI, 0));
        dir_rows.push_back(cfg_row(REG_KD, Q_ONE));
        dir_rows.push_back(cfg_row(REG_INV_DT, 32'h7FFF_FFFF));
        dir_rows.push_back(cfg_row(REG_FILTER_ALPHA, 32'h0001_FFFF));
        dir_rows.push_back(sample_row(D_MAX, D_MIN));
        dir_rows.push_back(sample_row(D_MIN, D_MAX));
        dir_rows.push_back(sample_row(0, 0));
        dir_rows.push_back(cfg_row(REG_SPARE_A, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_SPARE_B, 32'hFFFF_FFFF));
        dir_rows.push_back(sample_row(3 << 16, 1 << 16));
        dir_rows.push_back(cfg_row(REG_FILTER_ALPHA, 0));
        dir_rows.push_back(cfg_row(REG_INV_DT, 0));
        dir_rows.push_back(cfg_row(REG_KD, D_MIN));
        dir_rows.push_back(sample_row(D_MIN, 0));
        dir_rows.push_back(sample_row(7, -7));
        dir_rows.push_back(cfg_row(REG_FILTER_ALPHA, 1));
        dir_rows.push_back(cfg_row(REG_INV_DT, Q_ONE));
        dir_rows.push_back(cfg_row(REG_KD, D_MAX));
        dir_rows.push_back(sample_row(1 << 16, 0));
        dir_rows.push_back(sample_row(-(1 << 16), 1 << 16));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain_results();
                apb_write(dir_rows[k].reg_idx, dir_rows[k].wdata);
                settings_used++;
            end else begin
                offer_sample(dir_rows[k].setpoint, dir_rows[k].measurement, dir_rows[k].known,
                             dir_rows[k].drive, dir_rows[k].clamped);
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            apb_write(REG_KP, rand_gain());
            apb_write(REG_KI, rand_gain());
            apb_write(REG_KD, rand_gain());
            apb_write(REG_INV_DT, {1'($urandom), rand_rate()});
            apb_write(REG_FILTER_ALPHA, {15'($urandom), rand_alpha()});
            apb_write(REG_INTEGRAL_LIMIT, {1'($urandom), rand_limit()});
            if ($urandom_range(0, 3) == 0) begin
                apb_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            end
            settings_used++;
            if (phase == HOLD_PHASE) begin
                hold_toggle <= ~hold_toggle;
            end
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
                    drain_results();
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    if (phase == HOLD_PHASE) begin
                        gap = 0;
                    end
                    if (gap > 0) begin
                        sample_bus.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                sp = rand_value();
                if ($urandom_range(0, 1) == 0) begin
                    ms = rand_value();
                end else begin
                    ms = sp + $signed($urandom_range(0, 8 << 16)) - 32'sd262144;
                end
                offer_sample(sp, ms, 1'b0, '0, 1'b0);
                burst_left--;
            end
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Ran %0d samples through %0d register settings, checked %0d result beats.",
                 samples_taken, settings_used, results_checked);
        $display("Integral clamping was reported on %0d of those beats.", clamped_seen);
        if (fail_count == 0) begin
            $display("pid_filtered_derivative_top verification clean");
        end else begin
            $display("pid_filtered_derivative_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_in_if.sv
hw/rtl/pfd_out_if.sv
hw/rtl/pfd_regs.sv
hw/rtl/pfd_ctrl.sv
hw/rtl/pfd_dp.sv
hw/rtl/pid_filtered_derivative_top.sv
tb/sv/testbench.sv
